// ===== rtl/core/hasa_pkg.sv =====
// ----------------------------------------------------------------------------
// hasa_pkg
// Shared widths, register indexes, types and helpers of the highest-averages
// seat allocation block.
// ----------------------------------------------------------------------------
package hasa_pkg;

  localparam int unsigned MaxParties = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned IdxW       = $clog2(MaxParties);
  localparam int unsigned CountW     = $clog2(MaxParties + 1);
  localparam int unsigned VoteW      = 30;
  localparam int unsigned SeatW      = 10;
  localparam int unsigned TotalW     = VoteW + IdxW;
  localparam int unsigned FracW      = 16;
  localparam int unsigned DivW       = SeatW + 1;
  localparam int unsigned ProdW      = VoteW + DivW;
  localparam int unsigned BarProdW   = TotalW + FracW;
  localparam int unsigned OutIdxW    = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDivisorRule      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSeatsToFill      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgThresholdFraction = 2'd2;

  typedef struct packed {
    logic             divisor_rule;
    logic [SeatW-1:0] seats_to_fill;
    logic [FracW-1:0] threshold_fraction;
  } cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic [IdxW-1:0]  rd_addr;
    logic             vote_we;
    logic             seat_we;
    logic [IdxW-1:0]  wr_addr;
    logic [VoteW-1:0] vote_wdata;
    logic [SeatW-1:0] seat_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [VoteW-1:0] vote;
    logic [SeatW-1:0] seats;
  } mem_rsp_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BAR,
    ST_SEAT,
    ST_MUL,
    ST_CMP,
    ST_UPD,
    ST_EMIT_RD,
    ST_EMIT
  } state_e;

  // D'Hondt: s+1, Sainte-Lague: 2s+1
  function automatic logic [DivW-1:0] divisor_of(input logic rule,
                                                 input logic [SeatW-1:0] seats);
    if (rule) begin
      divisor_of = {seats, 1'b1};
    end else begin
      divisor_of = DivW'(seats) + DivW'(1);
    end
  endfunction

endpackage

// ===== rtl/core/hasa_if.sv =====
// ----------------------------------------------------------------------------
// hasa channel interfaces
// Valid/ready channels for party items, result items and register writes.
// ----------------------------------------------------------------------------
interface hasa_in_if;
  logic                        valid;
  logic                        ready;
  logic [hasa_pkg::VoteW-1:0]  party_votes;
  logic                        last_party;

  modport source (output valid, output party_votes, output last_party, input ready);
  modport sink   (input valid, input party_votes, input last_party, output ready);
endinterface

interface hasa_out_if;
  logic                         valid;
  logic                         ready;
  logic [hasa_pkg::OutIdxW-1:0] party_index;
  logic [hasa_pkg::SeatW-1:0]   seats_won;
  logic                         last_result;

  modport source (output valid, output party_index, output seats_won,
                  output last_result, input ready);
  modport sink   (input valid, input party_index, input seats_won,
                  input last_result, output ready);
endinterface

interface hasa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hasa_pkg::CfgIdxW-1:0]  index;
  logic [hasa_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/highest_averages_seat_allocation.sv =====
// ----------------------------------------------------------------------------
// highest_averages_seat_allocation
// D'Hondt / Sainte-Lague seat allocation over up to 16 loaded parties.
// ----------------------------------------------------------------------------
// Party items load at one per cycle into the vote memory. The item marked
// last_party starts allocation: the ST_BAR state computes the threshold, then
// every seat scans all loaded parties through the single read port of the
// vote/seat memories and the shared quotient compare (read, multiply,
// compare per party), then writes the winner's seat count back. Results
// follow one per loaded party in load order. Input is held off from the last
// party until the final result is taken; configuration writes are always
// accepted and belong between elections.
module highest_averages_seat_allocation (
  input  logic       clk_i,
  input  logic       rst_ni,
  hasa_in_if.sink    in_i,
  hasa_out_if.source out_o,
  hasa_cfg_if.sink   cfg_i
);
  import hasa_pkg::*;

  cfg_t     cfg;
  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  hasa_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  hasa_store u_store (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  hasa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .cfg_i     (cfg),
    .mem_req_o (mem_req),
    .mem_rsp_i (mem_rsp)
  );

endmodule

// ===== rtl/core/hasa_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hasa_cfg_regs
// Configuration registers: divisor rule, seat count and threshold fraction.
// ----------------------------------------------------------------------------
module hasa_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  hasa_cfg_if.sink        cfg_i,
  output hasa_pkg::cfg_t  cfg_o
);
  import hasa_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgDivisorRule:       cfg_d.divisor_rule       = cfg_i.data[0];
        CfgSeatsToFill:       cfg_d.seats_to_fill      = cfg_i.data[SeatW-1:0];
        CfgThresholdFraction: cfg_d.threshold_fraction = cfg_i.data[FracW-1:0];
        default:              cfg_d = cfg_q; // unknown index: ignore
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/hasa_store.sv =====
// ----------------------------------------------------------------------------
// hasa_store
// Vote and seat memories: one write and one registered read per cycle each,
// both read at the same address.
// ----------------------------------------------------------------------------
module hasa_store (
  input  logic               clk_i,
  input  hasa_pkg::mem_req_t req_i,
  output hasa_pkg::mem_rsp_t rsp_o
);
  import hasa_pkg::*;

  logic [VoteW-1:0] vote_mem [MaxParties];
  logic [SeatW-1:0] seat_mem [MaxParties];
  mem_rsp_t         rsp_q;

  always_ff @(posedge clk_i) begin
    if (req_i.vote_we) begin
      vote_mem[req_i.wr_addr] <= req_i.vote_wdata;
    end
    if (req_i.seat_we) begin
      seat_mem[req_i.wr_addr] <= req_i.seat_wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rsp_q.vote  <= vote_mem[req_i.rd_addr];
      rsp_q.seats <= seat_mem[req_i.rd_addr];
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/core/hasa_ctrl.sv =====
// ----------------------------------------------------------------------------
// hasa_ctrl
// Load sequencer, per-seat party scan with cross-multiplied quotient compare,
// seat write-back and result emission.
// ----------------------------------------------------------------------------
module hasa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  hasa_in_if.sink            in_i,
  hasa_out_if.source         out_o,
  input  hasa_pkg::cfg_t     cfg_i,
  output hasa_pkg::mem_req_t mem_req_o,
  input  hasa_pkg::mem_rsp_t mem_rsp_i
);
  import hasa_pkg::*;

  state_e state_q, state_d;

  logic [CountW-1:0] count_q, count_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [SeatW-1:0]  seat_cnt_q, seat_cnt_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              found_q, found_d;

  logic [TotalW-1:0] bar_q, bar_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic [VoteW-1:0]  best_v_q, best_v_d;
  logic [SeatW-1:0]  best_s_q, best_s_d;
  logic [VoteW-1:0]  cur_v_q, cur_v_d;
  logic [SeatW-1:0]  cur_s_q, cur_s_d;
  logic [ProdW-1:0]  lhs_q, lhs_d;
  logic [ProdW-1:0]  rhs_q, rhs_d;
  logic              elig_q, elig_d;

  logic                in_fire;
  logic                out_fire;
  logic                store_ok;
  logic                idx_last;
  logic                emit_end;
  logic                seats_done;
  logic [DivW-1:0]     div_best;
  logic [DivW-1:0]     div_cur;
  logic [BarProdW-1:0] bar_prod;

  assign in_fire    = in_i.valid & in_i.ready;
  assign out_fire   = out_o.valid & out_o.ready;
  assign store_ok   = count_q < CountW'(MaxParties);
  assign idx_last   = (CountW'(idx_q) + CountW'(1)) == count_q;
  assign emit_end   = idx_last | (idx_q == IdxW'(MaxResults - 1));
  assign seats_done = seat_cnt_q == cfg_i.seats_to_fill;
  assign div_best   = divisor_of(cfg_i.divisor_rule, best_s_q);
  assign div_cur    = divisor_of(cfg_i.divisor_rule, mem_rsp_i.seats);
  assign bar_prod   = BarProdW'(total_q * cfg_i.threshold_fraction);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:    if (in_fire && in_i.last_party) state_d = ST_BAR;
      ST_BAR:     state_d = ST_SEAT;
      ST_SEAT:    state_d = seats_done ? ST_EMIT_RD : ST_MUL;
      ST_MUL:     state_d = ST_CMP;
      ST_CMP:     state_d = idx_last ? ST_UPD : ST_MUL;
      ST_UPD:     state_d = ST_SEAT;
      ST_EMIT_RD: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_fire) begin
          state_d = emit_end ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default:    state_d = ST_LOAD;
    endcase
  end

  // handshakes and memory requests
  always_comb begin
    in_i.ready        = 1'b0;
    out_o.valid       = 1'b0;
    out_o.party_index = OutIdxW'(idx_q);
    out_o.seats_won   = mem_rsp_i.seats;
    out_o.last_result = idx_last;
    mem_req_o         = '0;
    case (state_q)
      ST_LOAD: begin
        in_i.ready = 1'b1;
        if (in_fire && store_ok) begin
          mem_req_o.vote_we    = 1'b1;
          mem_req_o.seat_we    = 1'b1;
          mem_req_o.wr_addr    = count_q[IdxW-1:0];
          mem_req_o.vote_wdata = in_i.party_votes;
          mem_req_o.seat_wdata = '0;
        end
      end
      ST_SEAT: begin
        mem_req_o.rd_en   = !seats_done;
        mem_req_o.rd_addr = '0;
      end
      ST_MUL: begin
        // prefetch the next party while this one is multiplied
        mem_req_o.rd_en   = !idx_last;
        mem_req_o.rd_addr = idx_q + IdxW'(1);
      end
      ST_UPD: begin
        mem_req_o.seat_we    = found_q;
        mem_req_o.wr_addr    = best_idx_q;
        mem_req_o.seat_wdata = best_s_q + SeatW'(1);
      end
      ST_EMIT_RD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = idx_q;
      end
      ST_EMIT: begin
        out_o.valid = 1'b1;
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    count_d    = count_q;
    total_d    = total_q;
    seat_cnt_d = seat_cnt_q;
    idx_d      = idx_q;
    found_d    = found_q;
    bar_d      = bar_q;
    best_idx_d = best_idx_q;
    best_v_d   = best_v_q;
    best_s_d   = best_s_q;
    cur_v_d    = cur_v_q;
    cur_s_d    = cur_s_q;
    lhs_d      = lhs_q;
    rhs_d      = rhs_q;
    elig_d     = elig_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (store_ok) begin
            count_d = count_q + CountW'(1);
            total_d = total_q + TotalW'(in_i.party_votes);
          end
          seat_cnt_d = '0;
        end
      end
      ST_BAR: begin
        bar_d = bar_prod[BarProdW-1:FracW];
      end
      ST_SEAT: begin
        idx_d   = '0;
        found_d = 1'b0;
      end
      ST_MUL: begin
        cur_v_d = mem_rsp_i.vote;
        cur_s_d = mem_rsp_i.seats;
        elig_d  = TotalW'(mem_rsp_i.vote) >= bar_q;
        lhs_d   = ProdW'(mem_rsp_i.vote * div_best);
        rhs_d   = ProdW'(best_v_q * div_cur);
      end
      ST_CMP: begin
        // strictly greater keeps the lower index on a tie
        if (elig_q && (!found_q || (lhs_q > rhs_q))) begin
          found_d    = 1'b1;
          best_idx_d = idx_q;
          best_v_d   = cur_v_q;
          best_s_d   = cur_s_q;
        end
        if (!idx_last) begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_UPD: begin
        seat_cnt_d = seat_cnt_q + SeatW'(1);
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (emit_end) begin
            count_d = '0;
            total_d = '0;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      total_q    <= '0;
      seat_cnt_q <= '0;
      idx_q      <= '0;
      found_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      total_q    <= total_d;
      seat_cnt_q <= seat_cnt_d;
      idx_q      <= idx_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bar_q      <= bar_d;
    best_idx_q <= best_idx_d;
    best_v_q   <= best_v_d;
    best_s_q   <= best_s_d;
    cur_v_q    <= cur_v_d;
    cur_s_q    <= cur_s_d;
    lhs_q      <= lhs_d;
    rhs_q      <= rhs_d;
    elig_q     <= elig_d;
  end

endmodule

// ===== rtl/core/hasa_checker.sv =====
// ----------------------------------------------------------------------------
// hasa_checker
// Port-level checks of the seat allocation block, bound to the top level.
// ----------------------------------------------------------------------------
module hasa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_last_party_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [hasa_pkg::OutIdxW-1:0] out_party_index_i,
  input logic [hasa_pkg::SeatW-1:0]   out_seats_won_i,
  input logic                         out_last_result_i
);
  import hasa_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_party_index_i)
      && $stable(out_seats_won_i) && $stable(out_last_result_i))
    else $error("stalled result changed");

  // no party is taken while results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready during result emission");

  // the last party starts allocation and closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_party_i |=> !in_ready_i)
    else $error("input still ready after last party");

  // after the final result, the block returns to loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_result_i |=> !out_valid_i && in_ready_i)
    else $error("no return to loading after final result");

endmodule

bind highest_averages_seat_allocation hasa_checker u_hasa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_last_party_i   (in_i.last_party),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_party_index_i (out_o.party_index),
  .out_seats_won_i   (out_o.seats_won),
  .out_last_result_i (out_o.last_result)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// highest-averages seat allocation testbench
// Feeds elections of party vote counts through the valid/ready party channel,
// predicts each party's seat count from a behavioral allocator, and checks
// every result item in order. Register settings change between elections
// while the block is idle. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import hasa_pkg::*;

  localparam int unsigned LimitCycles  = 1000000;
  localparam int unsigned RandomItems  = 470;
  localparam int unsigned HoldCycles   = 2000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailCycles   = 64;
  localparam int unsigned ReportLimit  = 10;
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;

  typedef struct packed {
    logic [VoteW-1:0] votes;
    logic             last;
  } party_t;

  typedef struct packed {
    logic [OutIdxW-1:0] party_index;
    logic [SeatW-1:0]   seats_won;
    logic               last_result;
  } tally_t;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;
  typedef enum int {VS_WIDE, VS_FEW, VS_EQUAL, VS_MIXED} vote_style_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  hasa_in_if  party_ch ();
  hasa_out_if tally_ch ();
  hasa_cfg_if reg_ch ();

  highest_averages_seat_allocation dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (party_ch),
    .out_o  (tally_ch),
    .cfg_i  (reg_ch)
  );

  always #5 clk_i = ~clk_i;

  // allocator state and register copies
  logic             rule_sl;
  logic [SeatW-1:0] seat_goal;
  logic [FracW-1:0] cut_frac;
  logic [VoteW-1:0] votes_held [MaxParties];
  logic [SeatW-1:0] seats_held [MaxParties];
  int unsigned      loaded;
  longint unsigned  votes_sum;

  party_t parties_waiting [$];
  tally_t expected_tallies [$];

  int unsigned fault_count;
  int unsigned results_seen;
  int unsigned items_taken;
  int unsigned elections_done;
  int unsigned settings_used;
  int unsigned overflow_runs;
  int unsigned random_loaded;
  int unsigned cycle_count;

  // sender pacing
  int unsigned burst_left;
  int unsigned gap_left;

  // receiver pacing
  rx_mode_e    rx_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  int unsigned hold_requests;
  int unsigned hold_served;

  function automatic logic [DivW-1:0] seat_divisor(input logic [SeatW-1:0] seats);
    return rule_sl ? {seats, 1'b1} : DivW'(seats) + DivW'(1);
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    case (idx)
      CfgDivisorRule:       rule_sl   = data[0];
      CfgSeatsToFill:       seat_goal = data[SeatW-1:0];
      CfgThresholdFraction: cut_frac  = data[FracW-1:0];
      default: ;
    endcase
  endfunction

  // Store one party; on the last one, hand out the seats and queue the tallies.
  function automatic void load_party(input logic [VoteW-1:0] votes, input logic last);
    longint unsigned bar, lhs, rhs;
    int unsigned     best;
    bit              found;
    if (loaded < MaxParties) begin
      votes_held[loaded] = votes;
      seats_held[loaded] = '0;
      loaded++;
      votes_sum += votes;
    end
    if (!last) return;
    bar = (votes_sum * 64'(cut_frac)) >> 16;
    for (int s = 0; s < seat_goal; s++) begin
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < loaded; i++) begin
        if (64'(votes_held[i]) < bar) continue;
        if (!found) begin
          found = 1'b1;
          best  = i;
        end else begin
          lhs = 64'(votes_held[i]) * 64'(seat_divisor(seats_held[best]));
          rhs = 64'(votes_held[best]) * 64'(seat_divisor(seats_held[i]));
          if (lhs > rhs) best = i;
        end
      end
      if (found) seats_held[best] = seats_held[best] + SeatW'(1);
    end
    for (int i = 0; i < loaded; i++) begin
      expected_tallies.push_back('{OutIdxW'(i), seats_held[i], i + 1 == loaded});
    end
    for (int i = 0; i < MaxParties; i++) seats_held[i] = '0;
    loaded    = 0;
    votes_sum = 0;
    elections_done++;
  endfunction

  function automatic void check_tally(input tally_t got);
    tally_t want;
    results_seen++;
    if (expected_tallies.size() == 0) begin
      fault_count++;
      if (fault_count <= ReportLimit) begin
        $display("unexpected result: party %0d seats %0d last %0b",
                 got.party_index, got.seats_won, got.last_result);
      end
      return;
    end
    want = expected_tallies.pop_front();
    if (got.party_index !== want.party_index || got.seats_won !== want.seats_won ||
        got.last_result !== want.last_result) begin
      fault_count++;
      if (fault_count <= ReportLimit) begin
        $display("mismatch: want party %0d seats %0d last %0b, got party %0d seats %0d last %0b",
                 want.party_index, want.seats_won, want.last_result,
                 got.party_index, got.seats_won, got.last_result);
      end
    end
  endfunction

  function automatic void queue_party(input logic [VoteW-1:0] votes, input logic last);
    parties_waiting.push_back('{votes, last});
  endfunction

  function automatic void random_election(input int unsigned max_n);
    int unsigned      n;
    vote_style_e      style;
    logic [VoteW-1:0] common, v;
    if (max_n == MaxParties && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(MaxParties + 1, MaxParties + 4);
    end else begin
      n = $urandom_range(1, max_n);
    end
    style  = vote_style_e'($urandom_range(0, 3));
    common = VoteW'($urandom());
    for (int i = 0; i < n; i++) begin
      case (style)
        VS_WIDE:  v = VoteW'($urandom());
        VS_FEW:   v = VoteW'($urandom_range(0, 12));
        VS_EQUAL: v = ($urandom_range(0, 3) == 0) ? VoteW'($urandom_range(0, 3)) : common;
        default:  v = ($urandom_range(0, 3) == 0) ? '0 :
                      VoteW'($urandom() >> $urandom_range(2, 31));
      endcase
      queue_party(v, i == n - 1);
    end
    random_loaded += (n > MaxParties) ? MaxParties : n;
    if (n > MaxParties) overflow_runs++;
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (parties_waiting.size() != 0 || party_ch.valid || expected_tallies.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= data;
    do @(posedge clk_i);
    while (!reg_ch.ready);
    apply_reg(idx, data);
  endtask

  // Drain the block, then write all registers with junk in the unused upper bits.
  task automatic set_config(input logic rule, input logic [SeatW-1:0] seats,
                            input logic [FracW-1:0] frac, input bit poke_unmapped);
    logic [CfgDataW-1:0] data;
    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    data = CfgDataW'($urandom());
    data[0] = rule;
    write_reg(CfgDivisorRule, data);
    data = CfgDataW'($urandom());
    data[SeatW-1:0] = seats;
    write_reg(CfgSeatsToFill, data);
    write_reg(CfgThresholdFraction, frac);
    if (poke_unmapped) write_reg(CfgUnmapped, CfgDataW'($urandom()));
    reg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // party driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      party_ch.valid       <= 1'b0;
      party_ch.party_votes <= '0;
      party_ch.last_party  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (party_ch.valid && party_ch.ready) begin
        load_party(parties_waiting[0].votes, parties_waiting[0].last);
        void'(parties_waiting.pop_front());
        items_taken++;
      end
      if (party_ch.valid && !party_ch.ready) begin
        // hold the offered item
      end else if (gap_left > 0 || parties_waiting.size() == 0) begin
        if (gap_left > 0) gap_left--;
        party_ch.valid <= 1'b0;
      end else begin
        party_ch.valid       <= 1'b1;
        party_ch.party_votes <= parties_waiting[0].votes;
        party_ch.last_party  <= parties_waiting[0].last;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) :
                                                     $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_ch.ready <= 1'b0;
      rx_mode   = RX_FREE;
      mode_left = 0;
      hold_left = 0;
    end else begin
      if (tally_ch.valid && tally_ch.ready) begin
        check_tally('{tally_ch.party_index, tally_ch.seats_won, tally_ch.last_result});
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        tally_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 200);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_FREE:   tally_ch.ready <= 1'b1;
          RX_COIN:   tally_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: tally_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   tally_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LimitCycles) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int unsigned      phase, elections, max_n;
    logic [SeatW-1:0] seats;
    logic [FracW-1:0] frac;
    int unsigned      pick;

    rst_ni = 1'b0;
    reg_ch.valid = 1'b0;
    reg_ch.index = CfgDivisorRule;
    reg_ch.data = '0;
    rule_sl = 1'b0;
    seat_goal = '0;
    cut_frac = '0;
    loaded = 0;
    votes_sum = 0;
    for (int i = 0; i < MaxParties; i++) begin
      votes_held[i] = '0;
      seats_held[i] = '0;
    end
    fault_count = 0;
    results_seen = 0;
    items_taken = 0;
    elections_done = 0;
    settings_used = 0;
    overflow_runs = 0;
    random_loaded = 0;
    hold_requests = 0;
    hold_served = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset: no seats to hand out
    queue_party('0, 1'b1);

    // D'Hondt, widest vote count, then all-zero parties win by lowest index
    set_config(1'b0, 10'd10, 16'h0000, 1'b1);
    queue_party({VoteW{1'b1}}, 1'b0);
    queue_party(30'd1, 1'b1);
    queue_party('0, 1'b0);
    queue_party('0, 1'b1);

    // Sainte-Lague with a low bar
    set_config(1'b1, 10'd7, 16'h1000, 1'b0);
    queue_party(30'd100, 1'b0);
    queue_party(30'd80, 1'b0);
    queue_party(30'd30, 1'b1);

    // bar above every party: no seat is handed out
    set_config(1'b1, 10'd1023, 16'hFFFF, 1'b0);
    queue_party(30'd1000, 1'b0);
    queue_party(30'd999, 1'b0);
    queue_party(30'd1, 1'b1);

    // full store: the last party arrives as the seventeenth and is dropped
    queue_party({VoteW{1'b1}}, 1'b0);
    for (int i = 1; i < MaxParties; i++) queue_party('0, 1'b0);
    queue_party({VoteW{1'b1}}, 1'b1);
    overflow_runs++;

    phase = 0;
    while (random_loaded < RandomItems) begin
      max_n     = MaxParties;
      elections = $urandom_range(2, 7);
      pick      = $urandom_range(0, 19);
      if (phase == 1 || (phase > 2 && pick == 0)) begin
        seats     = 10'd1023;
        max_n     = 3;
        elections = 2;
      end else if (phase == 2 || pick == 1) begin
        seats = '0;
      end else if (pick == 2) begin
        seats = SeatW'($urandom_range(100, 300));
        max_n = 6;
      end else begin
        seats = SeatW'($urandom_range(1, 24));
      end
      pick = $urandom_range(0, 19);
      if (pick < 5) frac = '0;
      else if (pick < 7) frac = 16'hFFFF;
      else if (pick < 15) frac = FracW'($urandom_range(0, 16'h1FFF));
      else frac = FracW'($urandom());
      set_config(1'($urandom_range(0, 1)), seats, frac, $urandom_range(0, 4) == 0);
      // first phase: stall results long while the sender keeps offering parties
      if (phase == 0) begin
        hold_requests++;
        elections = 6;
      end
      for (int e = 0; e < elections; e++) random_election(max_n);
      phase++;
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);

    $display("ran %0d elections from %0d party items (%0d with a full store)",
             elections_done, items_taken, overflow_runs);
    $display("checked %0d seat results across %0d register settings",
             results_seen, settings_used);
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
